@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define BSTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// condition must never be true outside reset
`define BSTS_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ rtl/core/bsts_pkg.sv @@
`default_nettype none

package bsts_pkg;

  // table geometry
  localparam int ROWS        = 64;
  localparam int ROW_WORDS   = 2;
  localparam int CHAR_BITS   = 8;
  localparam int ROW_POS     = ROW_WORDS * 32;
  localparam int QUERY_LEN   = 64;
  localparam int SEARCH_ROWS = (ROWS < 64) ? ROWS : 64;
  localparam int PLANE_W     = CHAR_BITS * ROW_POS;
  localparam int ROW_AW      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SIDX_W      = (SEARCH_ROWS > 1) ? $clog2(SEARCH_ROWS) : 1;

  // stream payload widths
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // function codes on the input tuser
  localparam logic [1:0] FUNC_STORE  = 2'd0;
  localparam logic [1:0] FUNC_QUERY  = 2'd1;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_QUERY,
    OP_SEARCH
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [5:0] row;
    logic [5:0] position;
    logic [7:0] char_value;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/bit_sliced_string_table_search_unit.sv @@
// Bit-sliced string table search. Items enter on the s_axis stream (tuser selects store row
// character, set query byte or search; code 3 and stores outside the table are taken and
// dropped) into a four-entry command queue, so the input takes one item per cycle while the
// queue has room. The back end works one command at a time: a query byte is written as its
// command is taken, a store is a read-modify-write of the row word through the separate read
// and write ports of the row memory, and a search takes the command, reads one row per cycle
// for the 64 rows, then gives the closing result; it stalls while a finished result waits on
// m_axis.
// Each search gives one item per matching row in ascending order, tlast on the final one,
// or a single not-found item. Rows never written read as empty through per-row valid flags
// cleared at reset, so no clearing pass follows reset.

`default_nettype none

module bit_sliced_string_table_search_unit
  import bsts_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire [IN_DATA_W-1:0]   s_axis_tdata,   // row[5:0], position[11:6], char_value[19:12]
  input  wire [IN_USER_W-1:0]   s_axis_tuser,   // func[1:0]
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // found[0], row_index[6:1]
  output logic                  m_axis_tlast    // last
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // accept and classify
  bsts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // execute against the table
  bsts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ rtl/core/bsts_ram.sv @@
`default_nettype none

module bsts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire                             clk_i,
  input  wire                             we_i,
  input  wire [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire [WIDTH-1:0]                 wdata_i,
  input  wire [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/core/bsts_front.sv @@
`default_nettype none
`include "assert_macros.svh"

module bsts_front
  import bsts_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire [IN_DATA_W-1:0]  in_data_i,   // row, position, char_value
  input  wire [IN_USER_W-1:0]  in_user_i,   // func
  output logic                 cmd_valid_o,
  input  wire                  cmd_ready_i,
  output cmd_t                 cmd_o
);

  cmd_t             queue_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QAW:0]     count_q, count_d;
  logic             full;
  logic             push;
  logic             pop;
  logic             keep;
  cmd_t             cmd_new;

  assign full       = (count_q == (QAW+1)'(QDEPTH));
  assign in_ready_o = !full;

  // classify the item; unused codes and stores outside the table are dropped
  always_comb begin
    cmd_new.row        = in_data_i[5:0];
    cmd_new.position   = in_data_i[11:6];
    cmd_new.char_value = in_data_i[19:12];
    cmd_new.op         = OP_STORE;
    keep               = 1'b0;
    case (in_user_i)
      FUNC_STORE: begin
        cmd_new.op = OP_STORE;
        keep       = (32'(in_data_i[5:0]) < ROWS) && (32'(in_data_i[11:6]) < ROW_POS);
      end
      FUNC_QUERY: begin
        cmd_new.op = OP_QUERY;
        keep       = 1'b1;
      end
      FUNC_SEARCH: begin
        cmd_new.op = OP_SEARCH;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push        = in_valid_i && in_ready_o && keep;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = queue_q[rd_ptr_q];

  // queue pointers
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QAW'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + QAW'(1) : rd_ptr_q;
    count_d  = count_q + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

  `BSTS_ASSERT(a_count_le_depth, clk_i, rst_ni, count_q <= (QAW+1)'(QDEPTH))
  `BSTS_NEVER(a_push_when_full, clk_i, rst_ni, push && full)

endmodule

`default_nettype wire

@@ rtl/core/bsts_back.sv @@
`default_nettype none
`include "assert_macros.svh"

module bsts_back
  import bsts_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cmd_valid_i,
  output logic                  cmd_ready_o,
  input  cmd_t                  cmd_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,   // found, row_index
  output logic                  out_last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STORE_WB,
    ST_SEARCH,
    ST_FINISH
  } st_e;

  st_e                 state_q, state_d;
  logic [SIDX_W-1:0]   idx_q, idx_d;
  logic                pend_valid_q, pend_valid_d;
  logic [SIDX_W-1:0]   pend_row_q, pend_row_d;
  logic [5:0]          st_pos_q, st_pos_d;
  logic [7:0]          st_chr_q, st_chr_d;
  logic [ROW_AW-1:0]   raddr_q, raddr;
  logic                out_valid_q, out_valid_d;
  logic                out_found_q, out_found_d;
  logic [5:0]          out_row_q, out_row_d;
  logic                out_last_q, out_last_d;

  logic [7:0]          query_q [QUERY_LEN];
  logic [ROWS-1:0]     row_vld_q;
  logic                q_we;
  logic                ram_we;
  logic [PLANE_W-1:0]  rdata;
  logic [PLANE_W-1:0]  rd_eff;
  logic [PLANE_W-1:0]  set_mask;
  logic                slot_free;
  logic                advance;

  logic [CHAR_BITS-1:0] row_bits [ROW_POS];
  logic [7:0]           row_chr  [QUERY_LEN];
  logic [QUERY_LEN-1:0] eq_v, qz_v, term_v, hit_v;
  logic                 row_match;

  // row planes, one row of all bit planes per word
  bsts_ram #(
    .WIDTH (PLANE_W),
    .DEPTH (ROWS)
  ) u_planes (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (raddr_q),
    .wdata_i (rd_eff | set_mask),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // a row never written reads as all zeros
  assign rd_eff = row_vld_q[raddr_q] ? rdata : '0;

  // bits to or into the row for a store
  always_comb begin
    set_mask = '0;
    for (int k = 0; k < CHAR_BITS; k++) begin
      set_mask[k*ROW_POS +: ROW_POS] = {ROW_POS{st_chr_q[k]}} &
                                       ({{(ROW_POS-1){1'b0}}, 1'b1} << st_pos_q);
    end
  end

  // gather the characters of the row being read
  for (genvar p = 0; p < ROW_POS; p++) begin : g_pos
    for (genvar k = 0; k < CHAR_BITS; k++) begin : g_bit
      assign row_bits[p][k] = rd_eff[k*ROW_POS + p];
    end
  end

  // per-position compare against the query
  for (genvar p = 0; p < QUERY_LEN; p++) begin : g_cmp
    if (p < ROW_POS) begin : g_in
      assign row_chr[p] = 8'(row_bits[p]);
    end else begin : g_out
      assign row_chr[p] = 8'd0;
    end
    assign eq_v[p] = !query_q[p][7] && (row_chr[p] == query_q[p]);
    assign qz_v[p] = (query_q[p] == 8'd0);
  end

  // first position that ends the compare decides: match only if it is a shared terminator, or if no position ends it
  assign term_v    = ~eq_v | qz_v;
  assign hit_v     = term_v & (~term_v + QUERY_LEN'(1));
  assign row_match = ~|(hit_v & ~eq_v);

  assign slot_free = !out_valid_q || out_ready_i;

  // sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_row_d   = pend_row_q;
    st_pos_d     = st_pos_q;
    st_chr_d     = st_chr_q;
    raddr        = raddr_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_found_d  = out_found_q;
    out_row_d    = out_row_q;
    out_last_d   = out_last_q;
    cmd_ready_o  = 1'b0;
    q_we         = 1'b0;
    ram_we       = 1'b0;
    advance      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_STORE: begin
              raddr    = ROW_AW'(cmd_i.row);
              st_pos_d = cmd_i.position;
              st_chr_d = cmd_i.char_value;
              state_d  = ST_STORE_WB;
            end
            OP_QUERY: begin
              q_we = 1'b1;
            end
            OP_SEARCH: begin
              idx_d        = '0;
              raddr        = '0;
              pend_valid_d = 1'b0;
              state_d      = ST_SEARCH;
            end
            default: begin
            end
          endcase
        end
      end
      ST_STORE_WB: begin
        ram_we  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SEARCH: begin
        advance = 1'b1;
        if (row_match && pend_valid_q) begin
          // previous match is now known not to be the last one
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_found_d = 1'b1;
            out_row_d   = 6'(pend_row_q);
            out_last_d  = 1'b0;
            pend_row_d  = idx_q;
          end else begin
            advance = 1'b0;
          end
        end else if (row_match) begin
          pend_valid_d = 1'b1;
          pend_row_d   = idx_q;
        end
        if (advance) begin
          if (32'(idx_q) == SEARCH_ROWS - 1) begin
            state_d = ST_FINISH;
            raddr   = ROW_AW'(idx_q);
          end else begin
            idx_d = idx_q + SIDX_W'(1);
            raddr = ROW_AW'(idx_d);
          end
        end else begin
          raddr = ROW_AW'(idx_q);
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_found_d  = pend_valid_q;
          out_row_d    = pend_valid_q ? 6'(pend_row_q) : 6'd0;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      pend_row_q   <= '0;
      st_pos_q     <= '0;
      st_chr_q     <= '0;
      raddr_q      <= '0;
      out_valid_q  <= 1'b0;
      out_found_q  <= 1'b0;
      out_row_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      pend_row_q   <= pend_row_d;
      st_pos_q     <= st_pos_d;
      st_chr_q     <= st_chr_d;
      raddr_q      <= raddr;
      out_valid_q  <= out_valid_d;
      out_found_q  <= out_found_d;
      out_row_q    <= out_row_d;
      out_last_q   <= out_last_d;
    end
  end

  // query bytes and per-row written flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUERY_LEN; i++) begin
        query_q[i] <= 8'd0;
      end
      row_vld_q <= '0;
    end else begin
      if (q_we) begin
        query_q[cmd_i.position] <= cmd_i.char_value;
      end
      if (ram_we) begin
        row_vld_q[raddr_q] <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {1'b0, out_row_q, out_found_q};
  assign out_last_o  = out_last_q;

  `BSTS_ASSERT(a_wb_one_cycle, clk_i, rst_ni, state_q == ST_STORE_WB |=> state_q == ST_IDLE)
  `BSTS_ASSERT(a_idx_in_range, clk_i, rst_ni, 32'(idx_q) < SEARCH_ROWS)
  `BSTS_NEVER(a_pend_outside_search, clk_i, rst_ni,
              pend_valid_q && (state_q == ST_IDLE || state_q == ST_STORE_WB))

endmodule

`default_nettype wire
